// ===== rtl/rogc_pkg.sv =====
`default_nettype none

package rogc_pkg;

    localparam int unsigned CountW  = 8;
    localparam int unsigned TicksW  = 16;
    localparam int unsigned NumGate = 4;
    localparam int unsigned NumEntry = 2;  // gates 0..1 are entries, the rest exits
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    // register indexes on the write port
    localparam logic [CfgIdxW-1:0] CFG_MAX_OCC    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_WARN_ABOVE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_FULL_ABOVE = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SHORT_BEEP = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LONG_BEEP  = 3'd4;

    // register reset values
    localparam logic [CountW-1:0] RST_MAX_OCC    = 8'd20;
    localparam logic [CountW-1:0] RST_WARN_ABOVE = 8'd14;
    localparam logic [CountW-1:0] RST_FULL_ABOVE = 8'd19;
    localparam logic [TicksW-1:0] RST_SHORT_BEEP = 16'd100;
    localparam logic [TicksW-1:0] RST_LONG_BEEP  = 16'd1000;

    typedef enum logic [1:0] {
        ST_NORMAL  = 2'd0,
        ST_WARNING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        LAMP_NORMAL = 2'd0,
        LAMP_DARK   = 2'd1,
        LAMP_ALARM  = 2'd2
    } t_lamp;

    // gate chain state: arm flags and people count
    typedef struct packed {
        logic [NumGate-1:0] armed;
        logic [CountW-1:0]  count;
    } t_gate_state;

endpackage

`default_nettype wire

// ===== rtl/rogc_gates.sv =====
`default_nettype none

module rogc_gates (
    input  wire rogc_pkg::t_gate_state              i_cur,
    input  wire logic [rogc_pkg::NumGate-1:0]       i_lines,
    input  wire logic [rogc_pkg::CountW-1:0]        i_max_occ,
    output rogc_pkg::t_gate_state                   o_nxt
);
    import rogc_pkg::*;

    // gates are served in order; each sees the count left by the ones before
    always_comb begin
        t_gate_state s;
        logic        allowed;
        s = i_cur;
        for (int g = 0; g < NumGate; g++) begin
            if (g < NumEntry) begin
                allowed = (s.count < i_max_occ);
            end else begin
                allowed = (s.count != '0);
            end
            if (allowed) begin
                if (i_lines[g]) begin
                    if (s.armed[g]) begin
                        if (g < NumEntry) begin
                            s.count = s.count + CountW'(1);
                        end else begin
                            s.count = s.count - CountW'(1);
                        end
                        s.armed[g] = 1'b0;
                    end
                end else begin
                    s.armed[g] = 1'b1;
                end
            end
        end
        o_nxt = s;
    end

endmodule

`default_nettype wire

// ===== rtl/room_occupancy_gate_counter_core.sv =====
`default_nettype none

// Channel   Dir  Handshake                  Payload
// ------    ---  -------------------------  ----------------------------------------
// in        in   i_in_valid / o_in_ready    i_entry_gate_a/b, i_exit_gate_a/b
// out       out  o_out_valid / i_out_ready  o_occupancy, o_room_status,
//                                           o_lamp_mode, o_buzzer_on
// cfg       in   i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// One beat per cycle while the output is not stalled. The whole poll update (gate
// chain, reclassify, buzzer timer) is one combinational pass from the state registers
// back into them, which load the result when the input beat is taken.
// The state registers double as the output register: a new beat is taken when
// the output is empty or being drained in the same cycle, so a stalled result
// holds. Synchronous active-low reset clears state and loads register defaults.

module room_occupancy_gate_counter_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_entry_gate_a,
    input  wire logic                             i_entry_gate_b,
    input  wire logic                             i_exit_gate_a,
    input  wire logic                             i_exit_gate_b,
    // output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [rogc_pkg::CountW-1:0]           o_occupancy,
    output logic [1:0]                            o_room_status,
    output logic [1:0]                            o_lamp_mode,
    output logic                                  o_buzzer_on,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [rogc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [rogc_pkg::CfgDataW-1:0]    i_cfg_data
);
    import rogc_pkg::*;

    // configuration
    logic [CountW-1:0] r_max_occ;
    logic [CountW-1:0] r_warn_above;
    logic [CountW-1:0] r_full_above;
    logic [TicksW-1:0] r_short_beep;
    logic [TicksW-1:0] r_long_beep;

    // block state; count and the status/lamp/buzzer regs also feed the output
    t_gate_state       r_gate;
    t_status           r_status;
    t_lamp             r_lamp;
    logic [TicksW-1:0] r_elapsed;
    logic [TicksW-1:0] r_deadline;
    logic              r_buzzer;
    logic              r_out_valid;

    t_gate_state       n_gate;
    t_status           n_status;
    t_lamp             n_lamp;
    logic [TicksW-1:0] n_elapsed;
    logic [TicksW-1:0] n_deadline;
    logic              n_buzzer;

    logic              accept;
    logic              changed;
    logic              rose;
    logic [TicksW-1:0] elapsed_mid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    rogc_gates u_gates (
        .i_cur     (r_gate),
        .i_lines   ({i_exit_gate_b, i_exit_gate_a, i_entry_gate_b, i_entry_gate_a}),
        .i_max_occ (r_max_occ),
        .o_nxt     (n_gate)
    );

    // The count register always equals the count at the last change, so a
    // change is simply new count vs. stored count.
    assign changed = (n_gate.count != r_gate.count);
    assign rose    = (n_gate.count > r_gate.count);

    always_comb begin
        n_status    = r_status;
        n_lamp      = r_lamp;
        n_buzzer    = r_buzzer;
        n_deadline  = r_deadline;
        elapsed_mid = r_elapsed;
        if (changed) begin
            elapsed_mid = '0;
            if (n_gate.count <= r_warn_above) begin
                n_status = ST_NORMAL;
            end else if (n_gate.count <= r_full_above) begin
                n_status = ST_WARNING;
            end else begin
                n_status = ST_FULL;
            end
            case (n_status)
                ST_NORMAL: begin
                    n_lamp = LAMP_NORMAL;
                end
                ST_WARNING: begin
                    n_lamp = LAMP_DARK;
                    if (rose) begin
                        n_buzzer   = 1'b1;
                        n_deadline = r_short_beep;
                    end
                end
                ST_FULL: begin
                    // full without a rise leaves lamp and buzzer alone
                    if (rose) begin
                        n_lamp     = LAMP_ALARM;
                        n_buzzer   = 1'b1;
                        n_deadline = r_long_beep;
                    end
                end
                default: begin
                    n_lamp = r_lamp;
                end
            endcase
        end
        // beep timeout, then saturating tick count
        if (elapsed_mid > n_deadline) begin
            n_buzzer = 1'b0;
        end
        if (elapsed_mid != {TicksW{1'b1}}) begin
            n_elapsed = elapsed_mid + TicksW'(1);
        end else begin
            n_elapsed = elapsed_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_occ    <= RST_MAX_OCC;
            r_warn_above <= RST_WARN_ABOVE;
            r_full_above <= RST_FULL_ABOVE;
            r_short_beep <= RST_SHORT_BEEP;
            r_long_beep  <= RST_LONG_BEEP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_OCC:    r_max_occ    <= i_cfg_data[CountW-1:0];
                CFG_WARN_ABOVE: r_warn_above <= i_cfg_data[CountW-1:0];
                CFG_FULL_ABOVE: r_full_above <= i_cfg_data[CountW-1:0];
                CFG_SHORT_BEEP: r_short_beep <= i_cfg_data[TicksW-1:0];
                CFG_LONG_BEEP:  r_long_beep  <= i_cfg_data[TicksW-1:0];
                default: ;      // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= '0;
            r_status    <= ST_NORMAL;
            r_lamp      <= LAMP_NORMAL;
            r_elapsed   <= '0;
            r_deadline  <= '0;
            r_buzzer    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_gate      <= n_gate;
                r_status    <= n_status;
                r_lamp      <= n_lamp;
                r_elapsed   <= n_elapsed;
                r_deadline  <= n_deadline;
                r_buzzer    <= n_buzzer;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_occupancy   = r_gate.count;
    assign o_room_status = r_status;
    assign o_lamp_mode   = r_lamp;
    assign o_buzzer_on   = r_buzzer;

endmodule

`default_nettype wire

// ===== tb/tb_room_occupancy_gate_counter_core.sv =====
`default_nettype none

// Self-checking bench for the room occupancy gate counter.
// Poll beats go in on a valid/ready channel, and one result beat comes back per poll.
// The bench keeps its own model of the gate arm flags, the count, the status, the lamp
// and the buzzer timer. It also tracks every register write seen on the config port.
module tb_room_occupancy_gate_counter_core;
    import rogc_pkg::*;

    localparam int unsigned HALF_PERIOD = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned IDLE_PCT    = 13;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned RETUNE_ROW  = 6;   // tight limits are loaded before this row
    localparam int unsigned NUM_ROWS    = 23;

    // one result beat as the block presents it
    typedef struct packed {
        logic [CountW-1:0] occ;
        t_status           status;
        t_lamp             lamp;
        logic              buzzer;
    } t_poll;

    // directed row: gate lines {exit_b, exit_a, entry_b, entry_a}, plus an optional
    // hand-computed result that replaces the model's prediction for that beat
    typedef struct packed {
        logic [3:0] gates;
        logic       pinned;
        t_poll      want;
    } t_row;

    // Rows 0..5 run with reset limits (max 20, warn 14, full 19).
    // From RETUNE_ROW on: max 4, warn 2, full 3, short beep 0, long beep 2.
    localparam t_row DIR_ROWS [NUM_ROWS] = '{
        '{4'b0000, 1'b1, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},  // idle poll after reset
        '{4'b1111, 1'b1, '{8'd2, ST_NORMAL,  LAMP_NORMAL, 1'b0}},  // exits unarmed, empty room
        '{4'b1111, 1'b1, '{8'd2, ST_NORMAL,  LAMP_NORMAL, 1'b0}},  // lines held: no recount
        '{4'b0000, 1'b1, '{8'd2, ST_NORMAL,  LAMP_NORMAL, 1'b0}},  // everyone re-arms
        '{4'b0011, 1'b1, '{8'd4, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b1100, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b0001, 1'b1, '{8'd3, ST_WARNING, LAMP_DARK,   1'b1}},  // rise into warning
        '{4'b0000, 1'b1, '{8'd3, ST_WARNING, LAMP_DARK,   1'b0}},  // zero-length beep ends
        '{4'b0011, 1'b1, '{8'd4, ST_FULL,    LAMP_ALARM,  1'b1}},  // entry b blocked at max
        '{4'b0010, 1'b1, '{8'd4, ST_FULL,    LAMP_ALARM,  1'b1}},  // blocked again, still armed
        '{4'b0100, 1'b1, '{8'd3, ST_WARNING, LAMP_DARK,   1'b1}},  // fall: no new beep
        '{4'b0000, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b0000, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b0000, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b0001, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b1000, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b1111, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b0000, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b1111, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b1100, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b0000, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b0101, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}},
        '{4'b1010, 1'b0, '{8'd0, ST_NORMAL,  LAMP_NORMAL, 1'b0}}
    };

    // ---------------------------------------------------------------- DUT hookup
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                out_ready  = 1'b0;
    logic [3:0]          gates      = '0;
    logic                cfg_we     = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index  = CFG_MAX_OCC;
    logic [CfgDataW-1:0] cfg_data   = '0;
    logic                in_ready;
    logic                out_valid;
    logic [CountW-1:0]   occupancy;
    logic [1:0]          room_status;
    logic [1:0]          lamp_mode;
    logic                buzzer_on;

    // The pinned result for a directed beat rides along with the payload.
    // It is updated in step with the payload, so the monitor reads the value that
    // belongs to the beat being accepted.
    logic                row_pinned = 1'b0;
    t_poll               row_want   = '0;

    room_occupancy_gate_counter_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_entry_gate_a (gates[0]),
        .i_entry_gate_b (gates[1]),
        .i_exit_gate_a  (gates[2]),
        .i_exit_gate_b  (gates[3]),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_occupancy    (occupancy),
        .o_room_status  (room_status),
        .o_lamp_mode    (lamp_mode),
        .o_buzzer_on    (buzzer_on),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ---------------------------------------------------------------- room model
    // The limits start at the register reset values. They follow every write
    // that the monitor sees on the config port.
    logic [CountW-1:0]  cap_occ   = RST_MAX_OCC;
    logic [CountW-1:0]  warn_lvl  = RST_WARN_ABOVE;
    logic [CountW-1:0]  full_lvl  = RST_FULL_ABOVE;
    logic [TicksW-1:0]  short_len = RST_SHORT_BEEP;
    logic [TicksW-1:0]  long_len  = RST_LONG_BEEP;

    logic [NumGate-1:0] arm_flags  = '0;
    logic [CountW-1:0]  head_count = '0;
    logic [CountW-1:0]  last_count = '0;
    t_status            room_st    = ST_NORMAL;
    t_lamp              lamp_st    = LAMP_NORMAL;
    logic [TicksW-1:0]  tick_age   = '0;
    logic [TicksW-1:0]  beep_limit = '0;
    logic               buzz       = 1'b0;

    t_poll pending_polls [$];

    // Advance the room by one poll tick and return what the outputs should show.
    function automatic t_poll poll_room(input logic [3:0] g);
        t_poll r;
        int    i;
        logic  entering;
        logic  allowed;
        logic  rose;
        // Gates are served in fixed order. Each gate sees the count left by the gates
        // served before it. A refused gate touches nothing, not even its arm flag.
        for (i = 0; i < NumGate; i++) begin
            entering = (i < NumEntry);
            allowed  = entering ? (head_count < cap_occ) : (head_count != '0);
            if (allowed) begin
                if (!g[i]) begin
                    arm_flags[i] = 1'b1;
                end else if (arm_flags[i]) begin
                    head_count   = entering ? head_count + 8'd1 : head_count - 8'd1;
                    arm_flags[i] = 1'b0;
                end
            end
        end
        // Reclassify only on a change of the count. Register writes alone
        // leave the status and the lamp as they are.
        if (head_count != last_count) begin
            rose     = (last_count < head_count);
            tick_age = '0;
            if (head_count <= warn_lvl)
                room_st = ST_NORMAL;
            else if (head_count <= full_lvl)
                room_st = ST_WARNING;
            else
                room_st = ST_FULL;
            case (room_st)
                ST_NORMAL: begin
                    lamp_st = LAMP_NORMAL;
                end
                ST_WARNING: begin
                    lamp_st = LAMP_DARK;
                    if (rose) begin
                        buzz       = 1'b1;
                        beep_limit = short_len;
                    end
                end
                default: begin
                    // full with a falling count keeps the lamp and the buzzer as they are
                    if (rose) begin
                        lamp_st    = LAMP_ALARM;
                        buzz       = 1'b1;
                        beep_limit = long_len;
                    end
                end
            endcase
            last_count = head_count;
        end
        if (tick_age > beep_limit)
            buzz = 1'b0;
        if (tick_age != '1)
            tick_age = tick_age + 16'd1;
        r.occ    = head_count;
        r.status = room_st;
        r.lamp   = lamp_st;
        r.buzzer = buzz;
        return r;
    endfunction

    // Only the low bits of each register are used. Indexes with no register are ignored.
    function automatic void load_reg(input logic [CfgIdxW-1:0] idx,
                                     input logic [CfgDataW-1:0] val);
        case (idx)
            CFG_MAX_OCC:    cap_occ   = val[CountW-1:0];
            CFG_WARN_ABOVE: warn_lvl  = val[CountW-1:0];
            CFG_FULL_ABOVE: full_lvl  = val[CountW-1:0];
            CFG_SHORT_BEEP: short_len = val[TicksW-1:0];
            CFG_LONG_BEEP:  long_len  = val[TicksW-1:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- monitor
    int unsigned mismatches  = 0;
    int unsigned beats_in    = 0;
    int unsigned results_out = 0;
    int unsigned buzz_beats  = 0;
    int unsigned settings    = 0;
    int unsigned cycles      = 0;
    int unsigned peak_occ    = 0;

    task automatic take_result();
        t_poll want;
        results_out++;
        if (32'(occupancy) > peak_occ)
            peak_occ = 32'(occupancy);
        if (buzzer_on === 1'b1)
            buzz_beats++;
        if (pending_polls.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d with nothing pending: occ %0d status %0d lamp %0d buzz %0b",
                         results_out, occupancy, room_status, lamp_mode, buzzer_on);
        end else begin
            want = pending_polls.pop_front();
            if (occupancy !== want.occ || room_status !== want.status ||
                lamp_mode !== want.lamp || buzzer_on !== want.buzzer) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d mismatch: occ exp %0d got %0d, status exp %0d got %0d,",
                              " lamp exp %0d got %0d, buzz exp %0b got %0b"},
                             results_out, want.occ, occupancy, want.status, room_status,
                             want.lamp, lamp_mode, want.buzzer, buzzer_on);
            end
        end
    endtask

    // Everything here is sampled at the clock edge, before any NBA update of that edge.
    // The ordering of the steps inside one edge does not matter. A config write never
    // falls in the same cycle as a beat, and a result beat always belongs to an
    // earlier poll.
    always @(posedge clk) begin
        t_poll p;
        if (rst_n) begin
            if (cfg_we)
                load_reg(cfg_index, cfg_data);
            if (out_valid && out_ready)
                take_result();
            if (in_valid && in_ready) begin
                beats_in++;
                p = poll_room(gates);
                pending_polls.push_back(row_pinned ? row_want : p);
            end
        end
    end

    // hard stop if the block wedges
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver
    bit          rx_idle   = 1'b1;
    bit          hold_req  = 1'b0;
    int unsigned hold_left = 0;

    // Random stalls on the result side. On request the receiver holds off for a
    // long stretch, so the result register fills up and the input side stalls.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(rx_idle && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- sender
    bit         tx_idle  = 1'b1;
    logic [3:0] gate_lvl = '0;

    // Offer one poll beat, with random gaps before it. The task returns at the edge
    // where the beat is taken, and it leaves valid high for the next call to lower
    // it or keep it.
    task automatic push_beat(input logic [3:0] g, input logic pin, input t_poll want);
        while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        gates      <= g;
        row_pinned <= pin;
        row_want   <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Let every pending result drain before the limits are touched.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_polls.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write all five registers back to back. The 8-bit registers get junk in
    // their upper data bits, which the block must ignore.
    task automatic program_regs(input logic [7:0] mx, input logic [7:0] wa,
                                input logic [7:0] fa, input logic [15:0] sb,
                                input logic [15:0] lb);
        logic [CfgIdxW-1:0]  idx  [5];
        logic [CfgDataW-1:0] vals [5];
        idx  = '{CFG_MAX_OCC, CFG_WARN_ABOVE, CFG_FULL_ABOVE, CFG_SHORT_BEEP, CFG_LONG_BEEP};
        vals = '{{8'($urandom_range(255)), mx}, {8'($urandom_range(255)), wa},
                 {8'($urandom_range(255)), fa}, sb, lb};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    // People walking through. Each gate line toggles with its own odds, so
    // most beats form clean arm/pass pulses. One beat in ten is a random
    // pattern that breaks the sequence.
    task automatic walk_gates(input int unsigned n, input int unsigned entry_pct,
                              input int unsigned exit_pct);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                gate_lvl = 4'($urandom_range(15));
            end else begin
                for (int i = 0; i < NumGate; i++)
                    if ($urandom_range(99) < ((i < NumEntry) ? entry_pct : exit_pct))
                        gate_lvl[i] = ~gate_lvl[i];
            end
            push_beat(gate_lvl, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, first at the reset limits and then at tight ones
        for (int k = 0; k < NUM_ROWS; k++) begin
            if (k == RETUNE_ROW) begin
                settle();
                program_regs(8'd4, 8'd2, 8'd3, 16'd0, 16'd2);
            end
            push_beat(DIR_ROWS[k].gates, DIR_ROWS[k].pinned, DIR_ROWS[k].want);
        end

        // back at the default limits, balanced traffic
        settle();
        program_regs(RST_MAX_OCC, RST_WARN_ABOVE, RST_FULL_ABOVE, RST_SHORT_BEEP, RST_LONG_BEEP);
        walk_gates(100, 50, 50);

        // Both sides stay busy the whole time and people mostly enter, up to the
        // top of the count. Every rise is a rise into full with the longest
        // possible beep, and every fall that leaves anyone inside is a full without a rise.
        settle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        program_regs(8'd255, 8'd0, 8'd0, 16'd0, 16'hFFFF);
        walk_gates(320, 90, 5);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // Zero max occupancy, so every entry is refused. Exits drain the room.
        settle();
        program_regs(8'd0, 8'd255, 8'd255, 16'hFFFF, 16'd0);
        walk_gates(300, 10, 90);

        // Crossed thresholds (warn above full), and a long receiver hold-off
        // at the start.
        settle();
        program_regs(8'd12, 8'd8, 8'd3, 16'd5, 16'd40);
        hold_req = 1'b1;
        walk_gates(70, 50, 50);

        settle();
        program_regs(8'd6, 8'd2, 8'd4, 16'd3, 16'd9);
        walk_gates(70, 60, 40);

        // a few small random settings, zero limits included
        for (int p = 0; p < 4; p++) begin
            settle();
            program_regs(8'($urandom_range(12)), 8'($urandom_range(12)),
                         8'($urandom_range(12)), 16'($urandom_range(8)),
                         16'($urandom_range(20)));
            walk_gates(25, 50, 50);
        end

        settle();
        repeat (4) @(posedge clk);
        if (pending_polls.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", pending_polls.size());
        end

        $display("%0d poll beats in, %0d results out, over %0d register settings",
                 beats_in, results_out, settings);
        $display("occupancy peaked at %0d; buzzer heard on %0d results; one %0d-cycle hold-off",
                 peak_occ, buzz_beats, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
